[hw/rtl/dgb_pkg.sv]
// ----------------------------------------------------------------------------
// dgb_pkg
// Shared types, constants and stage positions for the glass BSDF sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package dgb_pkg;

    // fixed point
    localparam int DIR_FRAC_BITS = 14;
    localparam int QS            = 30;
    localparam int QW            = QS + 1;
    localparam logic [QW-1:0] Q_ONE = QW'(1) << QS;
    localparam logic [16:0] DIR_LIM = 17'(1) << DIR_FRAC_BITS;
    localparam logic [13:0] IOR_ONE = 14'd4096;
    localparam logic [15:0] DENSITY_ONE = 16'h8000;
    localparam logic [15:0] WEIGHT_MAX = 16'hFFFF;

    // shared divider: 62 / 58 bit, 31 bit saturating quotient
    localparam int DIV_NUM_W = 62;
    localparam int DIV_DEN_W = 58;
    localparam int DIV_Q_W   = 31;
    localparam int DIV_LAT   = DIV_Q_W + 1;

    // shared square root: 62 bit radicand, 31 bit root
    localparam int SQRT_IN_W  = 62;
    localparam int SQRT_W     = 31;
    localparam int SQRT_REM_W = SQRT_W + 1;
    localparam int SQRT_LAT   = SQRT_W + 1;

    // derived configuration passes the operand registers and a divider after a write
    localparam int CFG_LAT = DIV_LAT + 1;

    // stage positions, stage 1 loaded at the accept edge
    localparam int ST_SCH = 5;
    localparam int ST_B   = (CFG_LAT > ST_SCH) ? CFG_LAT : ST_SCH + 1;
    localparam int ST_C   = ST_B + 1;
    localparam int ST_D   = ST_C + 1;
    localparam int ST_VZ  = ST_D + SQRT_LAT - 1;
    localparam int ST_SQ  = ST_VZ + 1;
    localparam int ST_L   = ST_SQ + 1;
    localparam int ST_LEN = ST_L + SQRT_LAT - 1;
    localparam int ST_DQ  = ST_LEN + 1;
    localparam int ST_O   = ST_DQ + DIV_LAT - 1;
    localparam int ST_P   = ST_O + 1;
    localparam int ST_W   = ST_P + 1;
    localparam int ST_WQ  = ST_W + DIV_LAT - 1;
    localparam int OUT_LAT = ST_WQ + 1;

    typedef enum logic [2:0] {
        REG_IOR     = 3'd0,
        REG_REFL_R  = 3'd1,
        REG_REFL_G  = 3'd2,
        REG_REFL_B  = 3'd3,
        REG_TRANS_R = 3'd4,
        REG_TRANS_G = 3'd5,
        REG_TRANS_B = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        PATH_TIR     = 2'd0,
        PATH_REFLECT = 2'd1,
        PATH_REFRACT = 2'd2
    } path_kind_t;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [14:0]        uniform_draw;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] new_dir_x;
        logic signed [15:0] new_dir_y;
        logic signed [15:0] new_dir_z;
        logic [15:0]        density;
        logic [15:0]        weight_red;
        logic [15:0]        weight_green;
        logic [15:0]        weight_blue;
        path_kind_t         path_kind;
    } out_item_t;

    typedef struct packed {
        logic [27:0] ior2;
        logic [30:0] n2_in;
        logic [33:0] n2_out;
        logic [30:0] n_in;
        logic [31:0] n_out;
        logic [29:0] r0;
        logic [15:0] refl_r;
        logic [15:0] refl_g;
        logic [15:0] refl_b;
        logic [15:0] trans_r;
        logic [15:0] trans_g;
        logic [15:0] trans_b;
    } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/dielectric_glass_bsdf_sample.sv]
// ----------------------------------------------------------------------------
// dielectric_glass_bsdf_sample
// Glass BSDF sampler: Snell refraction with Schlick Fresnel selection.
// ----------------------------------------------------------------------------
// Fully pipelined: one item may be started every cycle and busy never rises.
// Each item gives exactly one result, with done high for one cycle; the receiver
// must take it then. The path runs through a 31-step square root for the
// refracted z, a 31-step square root for the vector length, a 31-step
// normalising divider and a 31-step weight divider. The index-derived
// constants run through their own dividers after a write, and an item started
// straight after the write still meets the settled values.
// ----------------------------------------------------------------------------
`default_nettype none

module dielectric_glass_bsdf_sample (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire dgb_pkg::in_item_t  item,
    output logic                    done,
    output dgb_pkg::out_item_t      result,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);
    import dgb_pkg::*;

    typedef struct packed {
        logic        xneg;
        logic        yneg;
        logic        zneg;
        logic [QW-1:0] xq;
        logic [QW-1:0] yq;
        logic [QW-1:0] zq;
        logic [14:0] draw;
        logic [QW-1:0] sin2;
        logic [QW-1:0] c;
        logic [QW-1:0] cp;
        logic [33:0] bend;
        logic [QW-1:0] rpart;
        logic [QW-1:0] r;
        path_kind_t  kind;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [QW-1:0] vz;
        logic [31:0] sqx;
        logic [31:0] sqy;
        logic [31:0] sqz;
        logic [QW-1:0] len;
        logic [QW-1:0] ox;
        logic [QW-1:0] oy;
        logic [QW-1:0] oz;
        logic [31:0] rgb_r;
        logic [31:0] rgb_g;
        logic [31:0] rgb_b;
        logic [31:0] rf_r;
        logic [31:0] rf_g;
        logic [31:0] rf_b;
    } ctx_t;

    function automatic logic [QW-1:0] to_q(logic [15:0] raw);
        logic [16:0] mag;
        mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        if (mag > DIR_LIM)
            mag = DIR_LIM;
        return QW'(mag) << (QS - DIR_FRAC_BITS);
    endfunction

    function automatic logic signed [15:0] from_q(logic [QW-1:0] mag, logic neg);
        logic [15:0] m;
        m = 16'(mag >> (QS - DIR_FRAC_BITS));
        return neg ? -m : m;
    endfunction

    function automatic logic [15:0] sat16(logic [DIV_Q_W-1:0] q);
        return (q > DIV_Q_W'(WEIGHT_MAX)) ? WEIGHT_MAX : q[15:0];
    endfunction

    cfg_t cfg;

    ctx_t         pipe_reg [1:ST_WQ];
    ctx_t         nxt      [1:ST_WQ];
    logic [ST_WQ:1] vld_reg;

    logic [SQRT_IN_W-1:0] rad_vz, rad_len;
    logic [SQRT_W-1:0]    root_vz, root_len;
    logic [DIV_NUM_W-1:0] dnum_x, dnum_y, dnum_z;
    logic [DIV_DEN_W-1:0] dden;
    logic [DIV_Q_W-1:0]   dq_x, dq_y, dq_z;
    logic [DIV_NUM_W-1:0] wnum_r, wnum_g, wnum_b;
    logic [DIV_DEN_W-1:0] wden;
    logic [DIV_Q_W-1:0]   wq_r, wq_g, wq_b;

    out_item_t result_reg, result_next;
    logic      done_reg;

    dgb_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    always_comb
    begin
        logic [61:0] zz;
        logic [33:0] n2sel;
        logic [31:0] nrsel;
        logic [33:0] len2;
        logic [16:0] ft;
        logic [16:0] fr;
        ctx_t        p;

        for (int k = 2; k <= ST_WQ; k++)
            nxt[k] = pipe_reg[k-1];

        // decode
        nxt[1]      = '0;
        nxt[1].xneg = item.dir_x[15];
        nxt[1].yneg = item.dir_y[15];
        nxt[1].zneg = item.dir_z[15];
        nxt[1].xq   = to_q(item.dir_x);
        nxt[1].yq   = to_q(item.dir_y);
        nxt[1].zq   = to_q(item.dir_z);
        nxt[1].draw = item.uniform_draw;

        // sine squared and Schlick power chain
        p  = pipe_reg[1];
        zz = 62'(p.zq) * 62'(p.zq);
        nxt[2].sin2 = Q_ONE - QW'(zz >> QS);
        nxt[2].c    = Q_ONE - p.zq;
        p = pipe_reg[2];
        nxt[3].cp = QW'((62'(p.c) * 62'(p.c)) >> QS);
        p = pipe_reg[3];
        nxt[4].cp = QW'((62'(p.cp) * 62'(p.cp)) >> QS);
        p = pipe_reg[4];
        nxt[5].cp = QW'((62'(p.cp) * 62'(p.c)) >> QS);

        // Snell bend, Fresnel term and scaled tangent
        p     = pipe_reg[ST_B];
        n2sel = p.zneg ? cfg.n2_out : 34'(cfg.n2_in);
        nrsel = p.zneg ? cfg.n_out : 32'(cfg.n_in);
        nxt[ST_C].bend  = 34'((65'(n2sel) * 65'(p.sin2)) >> QS);
        nxt[ST_C].rpart = QW'((62'(Q_ONE - QW'(cfg.r0)) * 62'(p.cp)) >> QS);
        nxt[ST_C].vx    = 32'((63'(nrsel) * 63'(p.xq)) >> QS);
        nxt[ST_C].vy    = 32'((63'(nrsel) * 63'(p.yq)) >> QS);

        // path choice
        p = pipe_reg[ST_C];
        nxt[ST_D].r = QW'(cfg.r0) + p.rpart;
        if (p.bend > 34'(Q_ONE))
        begin
            nxt[ST_D].kind = PATH_TIR;
            rad_vz = '0;
        end
        else
        begin
            nxt[ST_D].kind = (QW'({p.draw, 15'd0}) < nxt[ST_D].r) ? PATH_REFLECT
                                                                 : PATH_REFRACT;
            rad_vz = SQRT_IN_W'(34'(Q_ONE) - p.bend) << QS;
        end

        // squared length terms
        p = pipe_reg[ST_VZ];
        nxt[ST_SQ].vz  = root_vz;
        nxt[ST_SQ].sqx = 32'((64'(p.vx) * 64'(p.vx)) >> 32);
        nxt[ST_SQ].sqy = 32'((64'(p.vy) * 64'(p.vy)) >> 32);
        nxt[ST_SQ].sqz = 32'((62'(root_vz) * 62'(root_vz)) >> 32);

        p       = pipe_reg[ST_SQ];
        len2    = 34'(p.sqx) + 34'(p.sqy) + 34'(p.sqz);
        rad_len = SQRT_IN_W'(len2) << 28;

        // normalise
        p = pipe_reg[ST_LEN];
        nxt[ST_DQ].len = root_len;
        dnum_x = DIV_NUM_W'(p.vx) << 28;
        dnum_y = DIV_NUM_W'(p.vy) << 28;
        dnum_z = DIV_NUM_W'(p.vz) << 28;
        dden   = DIV_DEN_W'(root_len);

        p  = pipe_reg[ST_O];
        ft = 17'((Q_ONE - p.r) >> 14);
        fr = 17'(p.r >> 14);
        if (p.len == '0)
        begin
            nxt[ST_P].ox = '0;
            nxt[ST_P].oy = '0;
            nxt[ST_P].oz = '0;
        end
        else
        begin
            nxt[ST_P].ox = (dq_x > Q_ONE) ? Q_ONE : dq_x;
            nxt[ST_P].oy = (dq_y > Q_ONE) ? Q_ONE : dq_y;
            nxt[ST_P].oz = (dq_z > Q_ONE) ? Q_ONE : dq_z;
        end
        nxt[ST_P].rgb_r = 32'(33'(cfg.trans_r) * 33'(ft));
        nxt[ST_P].rgb_g = 32'(33'(cfg.trans_g) * 33'(ft));
        nxt[ST_P].rgb_b = 32'(33'(cfg.trans_b) * 33'(ft));
        nxt[ST_P].rf_r  = 32'(33'(cfg.refl_r) * 33'(fr));
        nxt[ST_P].rf_g  = 32'(33'(cfg.refl_g) * 33'(fr));
        nxt[ST_P].rf_b  = 32'(33'(cfg.refl_b) * 33'(fr));

        // weight operands
        p = pipe_reg[ST_P];
        case (p.kind)
            PATH_TIR:
            begin
                wden   = DIV_DEN_W'(p.zq);
                wnum_r = DIV_NUM_W'(cfg.refl_r) << 22;
                wnum_g = DIV_NUM_W'(cfg.refl_g) << 22;
                wnum_b = DIV_NUM_W'(cfg.refl_b) << 22;
            end
            PATH_REFLECT:
            begin
                wden   = DIV_DEN_W'(p.zq);
                wnum_r = DIV_NUM_W'(p.rf_r) << 6;
                wnum_g = DIV_NUM_W'(p.rf_g) << 6;
                wnum_b = DIV_NUM_W'(p.rf_b) << 6;
            end
            default:
            begin
                if (!p.zneg)
                begin
                    wden   = DIV_DEN_W'(p.oz) << 18;
                    wnum_r = DIV_NUM_W'(p.rgb_r) * DIV_NUM_W'(cfg.ior2);
                    wnum_g = DIV_NUM_W'(p.rgb_g) * DIV_NUM_W'(cfg.ior2);
                    wnum_b = DIV_NUM_W'(p.rgb_b) * DIV_NUM_W'(cfg.ior2);
                end
                else
                begin
                    wden   = DIV_DEN_W'(cfg.ior2) * DIV_DEN_W'(p.oz);
                    wnum_r = DIV_NUM_W'(p.rgb_r) << QS;
                    wnum_g = DIV_NUM_W'(p.rgb_g) << QS;
                    wnum_b = DIV_NUM_W'(p.rgb_b) << QS;
                end
            end
        endcase
    end

    dgb_sqrt u_sqrt_vz  (.clk(clk), .rad(rad_vz),  .root(root_vz));
    dgb_sqrt u_sqrt_len (.clk(clk), .rad(rad_len), .root(root_len));

    dgb_div u_div_x (.clk(clk), .num(dnum_x), .den(dden), .quo(dq_x));
    dgb_div u_div_y (.clk(clk), .num(dnum_y), .den(dden), .quo(dq_y));
    dgb_div u_div_z (.clk(clk), .num(dnum_z), .den(dden), .quo(dq_z));

    dgb_div u_div_wr (.clk(clk), .num(wnum_r), .den(wden), .quo(wq_r));
    dgb_div u_div_wg (.clk(clk), .num(wnum_g), .den(wden), .quo(wq_g));
    dgb_div u_div_wb (.clk(clk), .num(wnum_b), .den(wden), .quo(wq_b));

    always_comb
    begin
        ctx_t p;
        p = pipe_reg[ST_WQ];
        result_next.path_kind    = p.kind;
        result_next.weight_red   = sat16(wq_r);
        result_next.weight_green = sat16(wq_g);
        result_next.weight_blue  = sat16(wq_b);
        case (p.kind)
            PATH_TIR:
            begin
                result_next.density   = DENSITY_ONE;
                result_next.new_dir_x = from_q(p.xq, !p.xneg);
                result_next.new_dir_y = from_q(p.yq, !p.yneg);
                result_next.new_dir_z = from_q(p.zq, p.zneg);
            end
            PATH_REFLECT:
            begin
                result_next.density   = 16'(p.r >> 15);
                result_next.new_dir_x = from_q(p.xq, !p.xneg);
                result_next.new_dir_y = from_q(p.yq, !p.yneg);
                result_next.new_dir_z = from_q(p.zq, p.zneg);
            end
            default:
            begin
                result_next.density   = 16'((Q_ONE - p.r) >> 15);
                result_next.new_dir_x = from_q(p.ox, !p.xneg);
                result_next.new_dir_y = from_q(p.oy, !p.yneg);
                result_next.new_dir_z = from_q(p.oz, !p.zneg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[ST_WQ-1:1], start};
            done_reg <= vld_reg[ST_WQ];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= ST_WQ; k++)
            pipe_reg[k] <= nxt[k];
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##OUT_LAT done)
        else $error("item result not delivered at fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[ST_WQ] |=> !done)
        else $error("result strobe without an item in the last stage");

    a_tir_density: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.path_kind == PATH_TIR) |-> result.density == DENSITY_ONE)
        else $error("internal reflection with density other than one");

endmodule

`default_nettype wire

[hw/rtl/dgb_div.sv]
// ----------------------------------------------------------------------------
// dgb_div
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
`default_nettype none

module dgb_div (
    input  wire logic                           clk,
    input  wire logic [dgb_pkg::DIV_NUM_W-1:0]  num,
    input  wire logic [dgb_pkg::DIV_DEN_W-1:0]  den,
    output logic      [dgb_pkg::DIV_Q_W-1:0]    quo
);
    import dgb_pkg::*;

    logic [DIV_DEN_W-1:0] rem_reg [0:DIV_Q_W];
    logic [DIV_DEN_W-1:0] den_reg [0:DIV_Q_W];
    logic [DIV_Q_W-1:0]   low_reg [0:DIV_Q_W];
    logic [DIV_Q_W-1:0]   quo_reg [0:DIV_Q_W];
    logic                 sat_reg [0:DIV_Q_W];

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
        sat_reg[0] <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]) >= den;
        den_reg[0] <= den;
        low_reg[0] <= num[DIV_Q_W-1:0];
        quo_reg[0] <= '0;
    end

    for (genvar i = 0; i < DIV_Q_W; i++)
    begin : g_step
        logic [DIV_DEN_W:0]   trial;
        logic                 ge;
        logic [DIV_DEN_W-1:0] rem_next;
        logic [DIV_Q_W-1:0]   quo_next;

        always_comb
        begin
            trial    = {rem_reg[i], low_reg[i][DIV_Q_W-1-i]};
            ge       = trial >= {1'b0, den_reg[i]};
            rem_next = ge ? DIV_DEN_W'(trial - {1'b0, den_reg[i]})
                          : trial[DIV_DEN_W-1:0];
            quo_next = quo_reg[i];
            quo_next[DIV_Q_W-1-i] = ge;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= rem_next;
            den_reg[i+1] <= den_reg[i];
            low_reg[i+1] <= low_reg[i];
            quo_reg[i+1] <= quo_next;
            sat_reg[i+1] <= sat_reg[i];
        end
    end

    assign quo = sat_reg[DIV_Q_W] ? '1 : quo_reg[DIV_Q_W];

endmodule

`default_nettype wire

[hw/rtl/dgb_sqrt.sv]
// ----------------------------------------------------------------------------
// dgb_sqrt
// Pipelined integer square root (floor), one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dgb_sqrt (
    input  wire logic                           clk,
    input  wire logic [dgb_pkg::SQRT_IN_W-1:0]  rad,
    output logic      [dgb_pkg::SQRT_W-1:0]     root
);
    import dgb_pkg::*;

    logic [SQRT_IN_W-1:0]  rad_reg  [0:SQRT_W];
    logic [SQRT_REM_W-1:0] rem_reg  [0:SQRT_W];
    logic [SQRT_W-1:0]     root_reg [0:SQRT_W];

    always_ff @(posedge clk)
    begin
        rad_reg[0]  <= rad;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
    end

    for (genvar i = 0; i < SQRT_W; i++)
    begin : g_step
        logic [SQRT_REM_W+1:0] trial;
        logic [SQRT_REM_W+1:0] test;
        logic                  ge;

        always_comb
        begin
            trial = {rem_reg[i], rad_reg[i][2*(SQRT_W-1-i)+1 -: 2]};
            test  = (SQRT_REM_W+2)'({root_reg[i], 2'b01});
            ge    = trial >= test;
        end

        always_ff @(posedge clk)
        begin
            rad_reg[i+1]  <= rad_reg[i];
            rem_reg[i+1]  <= ge ? SQRT_REM_W'(trial - test) : trial[SQRT_REM_W-1:0];
            root_reg[i+1] <= {root_reg[i][SQRT_W-2:0], ge};
        end
    end

    assign root = root_reg[SQRT_W];

endmodule

`default_nettype wire

[hw/rtl/dgb_cfg.sv]
// ----------------------------------------------------------------------------
// dgb_cfg
// Configuration registers and the constants derived from the index.
// ----------------------------------------------------------------------------
`default_nettype none

module dgb_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [15:0] wr_data,
    output dgb_pkg::cfg_t    cfg
);
    import dgb_pkg::*;

    logic [13:0] ior_reg;
    logic [15:0] refl_r_reg, refl_g_reg, refl_b_reg;
    logic [15:0] trans_r_reg, trans_g_reg, trans_b_reg;

    logic [13:0] ior_clamp;
    logic [13:0] ior_a_reg;
    logic [27:0] ior2_a_reg;
    logic [27:0] dd_a_reg;
    logic [28:0] ss_a_reg;
    logic [13:0] diff;
    logic [14:0] sum;

    logic [DIV_Q_W-1:0] q_n2, q_n, q_r0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ior_reg     <= 14'd6144;
            refl_r_reg  <= 16'hFFFF;
            refl_g_reg  <= 16'hFFFF;
            refl_b_reg  <= 16'hFFFF;
            trans_r_reg <= 16'hFFFF;
            trans_g_reg <= 16'hFFFF;
            trans_b_reg <= 16'hFFFF;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_IOR:     ior_reg     <= wr_data[13:0];
                REG_REFL_R:  refl_r_reg  <= wr_data;
                REG_REFL_G:  refl_g_reg  <= wr_data;
                REG_REFL_B:  refl_b_reg  <= wr_data;
                REG_TRANS_R: trans_r_reg <= wr_data;
                REG_TRANS_G: trans_g_reg <= wr_data;
                REG_TRANS_B: trans_b_reg <= wr_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ior_clamp = (ior_reg < IOR_ONE) ? IOR_ONE : ior_reg;
        diff      = ior_clamp - IOR_ONE;
        sum       = 15'(ior_clamp) + 15'(IOR_ONE);
    end

    always_ff @(posedge clk)
    begin
        ior_a_reg  <= ior_clamp;
        ior2_a_reg <= 28'(ior_clamp) * 28'(ior_clamp);
        dd_a_reg   <= 28'(diff) * 28'(diff);
        ss_a_reg   <= 29'(sum) * 29'(sum);
    end

    // 2^54 / ior^2, 2^42 / ior, d^2 * 2^30 / s^2
    dgb_div u_div_n2 (
        .clk (clk),
        .num (DIV_NUM_W'(1) << 54),
        .den (DIV_DEN_W'(ior2_a_reg)),
        .quo (q_n2)
    );

    dgb_div u_div_n (
        .clk (clk),
        .num (DIV_NUM_W'(1) << 42),
        .den (DIV_DEN_W'(ior_a_reg)),
        .quo (q_n)
    );

    dgb_div u_div_r0 (
        .clk (clk),
        .num (DIV_NUM_W'(dd_a_reg) << QS),
        .den (DIV_DEN_W'(ss_a_reg)),
        .quo (q_r0)
    );

    always_comb
    begin
        cfg.ior2    = ior2_a_reg;
        cfg.n2_in   = q_n2;
        cfg.n2_out  = 34'(ior2_a_reg) << 6;
        cfg.n_in    = q_n;
        cfg.n_out   = 32'(ior_a_reg) << 18;
        cfg.r0      = q_r0[29:0];
        cfg.refl_r  = refl_r_reg;
        cfg.refl_g  = refl_g_reg;
        cfg.refl_b  = refl_b_reg;
        cfg.trans_r = trans_r_reg;
        cfg.trans_g = trans_g_reg;
        cfg.trans_b = trans_b_reg;
    end

endmodule

`default_nettype wire

[bench/dielectric_glass_bsdf_sample_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dielectric_glass_bsdf_sample_chk
// Watches the item and result channels of the glass sampler, works out the
// expected result of every accepted item and compares it field by field.
// ----------------------------------------------------------------------------

module dielectric_glass_bsdf_sample_chk (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire dgb_pkg::in_item_t  item,
    input  wire logic               done,
    input  wire dgb_pkg::out_item_t result,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output int                      fail_count,
    output int                      pending
);
    import dgb_pkg::*;

    localparam logic [63:0] ONE30 = 64'd1 << 30;

    logic [63:0] ior_reg;
    logic [63:0] refl [3];
    logic [63:0] trans [3];
    out_item_t   sample_queue [$];

    assign pending = sample_queue.size();

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag30(logic [15:0] raw, output logic neg);
        logic [63:0] m;
        neg = raw[15];
        m = neg ? (64'h10000 - raw) : {48'd0, raw};
        if (m > 64'd16384) m = 64'd16384;
        return m << 16;
    endfunction

    function automatic logic [15:0] signed_dir(logic [63:0] mag, logic neg);
        logic [63:0] m;
        m = mag >> 16;
        return neg ? 16'(64'd0 - m) : 16'(m);
    endfunction

    function automatic logic [15:0] quot_sat(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        if (den == 0) return 16'hFFFF;
        q = num / den;
        return (q > 64'd65535) ? 16'hFFFF : 16'(q);
    endfunction

    function automatic out_item_t sample_glass(in_item_t it);
        out_item_t   o;
        logic        xn, yn, zn, entering;
        logic [63:0] xq, yq, zq, draw, ior, ior2, n2, sin2, bend, d, s, r0, c, c2, c4, c5;
        logic [63:0] r, f, t, n, vx, vy, vz, len2, len, ox, oy, oz, num;
        xq = mag30(it.dir_x, xn);
        yq = mag30(it.dir_y, yn);
        zq = mag30(it.dir_z, zn);
        draw = {49'd0, it.uniform_draw};
        ior = (ior_reg < 64'd4096) ? 64'd4096 : ior_reg;
        ior2 = ior * ior;
        entering = !zn;
        n2 = entering ? (64'd1 << 54) / ior2 : ior2 << 6;
        sin2 = ONE30 - ((zq * zq) >> 30);
        bend = (n2 * sin2) >> 30;
        o.new_dir_x = signed_dir(xq, !xn);
        o.new_dir_y = signed_dir(yq, !yn);
        o.new_dir_z = signed_dir(zq, zn);
        if (bend > ONE30) begin
            o.density = DENSITY_ONE;
            o.weight_red = quot_sat(refl[0] << 22, zq);
            o.weight_green = quot_sat(refl[1] << 22, zq);
            o.weight_blue = quot_sat(refl[2] << 22, zq);
            o.path_kind = PATH_TIR;
            return o;
        end
        d = (ior > 64'd4096) ? ior - 64'd4096 : 64'd4096 - ior;
        s = ior + 64'd4096;
        r0 = ((d * d) << 30) / (s * s);
        c = ONE30 - zq;
        c2 = (c * c) >> 30;
        c4 = (c2 * c2) >> 30;
        c5 = (c4 * c) >> 30;
        r = r0 + (((ONE30 - r0) * c5) >> 30);
        if ((draw << 15) < r) begin
            f = r >> 14;
            o.density = 16'(r >> 15);
            o.weight_red = quot_sat((refl[0] * f) << 6, zq);
            o.weight_green = quot_sat((refl[1] * f) << 6, zq);
            o.weight_blue = quot_sat((refl[2] * f) << 6, zq);
            o.path_kind = PATH_REFLECT;
            return o;
        end
        t = ONE30 - r;
        n = entering ? (64'd1 << 42) / ior : ior << 18;
        vx = (n * xq) >> 30;
        vy = (n * yq) >> 30;
        vz = root_floor((ONE30 - bend) << 30);
        len2 = ((vx * vx) >> 32) + ((vy * vy) >> 32) + ((vz * vz) >> 32);
        len = root_floor(len2 << 28);
        ox = 0;
        oy = 0;
        oz = 0;
        if (len != 0) begin
            ox = (vx << 28) / len;
            if (ox > ONE30) ox = ONE30;
            oy = (vy << 28) / len;
            if (oy > ONE30) oy = ONE30;
            oz = (vz << 28) / len;
            if (oz > ONE30) oz = ONE30;
        end
        f = t >> 14;
        o.new_dir_x = signed_dir(ox, !xn);
        o.new_dir_y = signed_dir(oy, !yn);
        o.new_dir_z = signed_dir(oz, entering);
        o.density = 16'(t >> 15);
        if (entering) begin
            o.weight_red = quot_sat(trans[0] * f * ior2, oz << 18);
            o.weight_green = quot_sat(trans[1] * f * ior2, oz << 18);
            o.weight_blue = quot_sat(trans[2] * f * ior2, oz << 18);
        end else begin
            o.weight_red = quot_sat((trans[0] * f) << 30, ior2 * oz);
            o.weight_green = quot_sat((trans[1] * f) << 30, ior2 * oz);
            o.weight_blue = quot_sat((trans[2] * f) << 30, ior2 * oz);
        end
        o.path_kind = PATH_REFRACT;
        return o;
    endfunction

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s expected %0h got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        if (!rst_n) begin
            ior_reg <= 64'd6144;
            for (int i = 0; i < 3; i++) begin
                refl[i] <= 64'd65535;
                trans[i] <= 64'd65535;
            end
            fail_count <= 0;
        end else begin
            if (start && !busy) sample_queue.push_back(sample_glass(item));
            if (done) begin
                if (sample_queue.size() == 0) begin
                    $error("result with no item outstanding");
                    fail_count++;
                end else begin
                    want = sample_queue.pop_front();
                    compare_field("new_dir_x", want.new_dir_x, result.new_dir_x);
                    compare_field("new_dir_y", want.new_dir_y, result.new_dir_y);
                    compare_field("new_dir_z", want.new_dir_z, result.new_dir_z);
                    compare_field("density", want.density, result.density);
                    compare_field("weight_red", want.weight_red, result.weight_red);
                    compare_field("weight_green", want.weight_green, result.weight_green);
                    compare_field("weight_blue", want.weight_blue, result.weight_blue);
                    compare_field("path_kind", 16'(want.path_kind), 16'(result.path_kind));
                end
            end
            if (cfg_wr_en) begin
                case (reg_index_t'(cfg_index))
                    REG_IOR:     ior_reg <= {50'd0, cfg_data[13:0]};
                    REG_REFL_R:  refl[0] <= {48'd0, cfg_data};
                    REG_REFL_G:  refl[1] <= {48'd0, cfg_data};
                    REG_REFL_B:  refl[2] <= {48'd0, cfg_data};
                    REG_TRANS_R: trans[0] <= {48'd0, cfg_data};
                    REG_TRANS_G: trans[1] <= {48'd0, cfg_data};
                    REG_TRANS_B: trans[2] <= {48'd0, cfg_data};
                    default: ;
                endcase
            end
        end
    end

endmodule

[bench/dielectric_glass_bsdf_sample_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dielectric_glass_bsdf_sample_tb
// Drives directed and random directions through the glass sampler under
// several index and colour settings; the checker predicts every result.
// ----------------------------------------------------------------------------

module dielectric_glass_bsdf_sample_tb;
    import dgb_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    in_item_t    item = '0;
    logic        done;
    out_item_t   result;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          fail_count;
    int          pending;

    always #4 clk = ~clk;

    dielectric_glass_bsdf_sample u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    dielectric_glass_bsdf_sample_chk u_chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'd16384;
            2: return 16'hC000;
            3: return 16'($urandom_range(0, 400));
            4: return -16'($urandom_range(0, 400));
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    task automatic write_reg(reg_index_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // start stays high between back-to-back items; it drops only for idling
    task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                               logic [14:0] u, bit idle);
        if (idle && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        start <= 1'b1;
        item <= '{dir_x: x, dir_y: y, dir_z: z, uniform_draw: u};
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (OUT_LAT + 10) @(negedge clk);
    endtask

    task automatic write_setting(logic [15:0] ior);
        write_reg(REG_IOR, ior);
        write_reg(REG_REFL_R, 16'($urandom_range(0, 65535)));
        write_reg(REG_REFL_G, 16'hFFFF);
        write_reg(REG_REFL_B, 16'h0000);
        write_reg(REG_TRANS_R, 16'($urandom_range(0, 65535)));
        write_reg(REG_TRANS_G, 16'h0000);
        write_reg(REG_TRANS_B, 16'hFFFF);
    endtask

    initial begin
        #5_000_000;
        $display("FAIL dielectric_glass_bsdf_sample");
        $finish;
    end

    initial begin
        logic [15:0] iors [5];
        iors = '{16'd6144, 16'd4096, 16'd16383, 16'd100, 16'h3FFF};
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: poles, grazing, clamping, draw extremes
        send_sample(16'd0, 16'd0, 16'd16384, 15'd0, 0);
        send_sample(16'd0, 16'd0, 16'hC000, 15'h7FFF, 0);
        send_sample(16'd16384, 16'd0, 16'd0, 15'd0, 0);
        send_sample(16'd16384, 16'd0, 16'd0, 15'h7FFF, 0);
        send_sample(16'hC000, 16'hC000, 16'd0, 15'h7FFF, 0);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 15'h7FFF, 0);
        send_sample(16'h8000, 16'h7FFF, 16'h8000, 15'd0, 0);
        send_sample(16'd11585, 16'd0, 16'hD2BF, 15'd100, 0);
        send_sample(16'd11585, 16'd0, 16'hD2BF, 15'h7FFF, 0);
        send_sample(16'd14000, 16'd2000, 16'hFFFF, 15'd5, 0);
        send_sample(16'd0, 16'd0, 16'd1, 15'h7FFF, 0);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h4000, 0);
        drain();
        for (int p = 0; p < 5; p++) begin
            write_setting(iors[p]);
            for (int i = 0; i < 250; i++)
                send_sample(rand_comp(), rand_comp(), rand_comp(),
                            15'($urandom_range(0, 32767)), p < 4);
            drain();
        end
        if (fail_count == 0)
            $display("PASS dielectric_glass_bsdf_sample");
        else
            $display("FAIL dielectric_glass_bsdf_sample");
        $finish;
    end

endmodule
